// ===== rtl/core/fpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

  // Fixed register and drive widths
  localparam int DRV_W  = 16;
  localparam int PL_W   = 16;
  localparam int W_W    = 16;
  localparam int IL_W   = 31;
  localparam int OL_W   = 15;
  localparam int CFG_DW = 31;
  localparam int CFG_IW = 3;
  localparam int PC_W   = 4;

  // Register reset values
  localparam logic [PL_W-1:0] P_LIMIT_RST  = 16'd1000;
  localparam logic [W_W-1:0]  P_WEIGHT_RST = 16'd256;
  localparam logic [IL_W-1:0] I_LIMIT_RST  = 31'd100000;
  localparam logic [W_W-1:0]  I_WEIGHT_RST = 16'd256;
  localparam logic [OL_W-1:0] O_LIMIT_RST  = 15'd32767;
  localparam logic [OL_W-1:0] MAX_OUT_RST  = 15'd32767;

  // Register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_P_LIMIT  = 3'd0,
    CFG_P_WEIGHT = 3'd1,
    CFG_I_LIMIT  = 3'd2,
    CFG_I_WEIGHT = 3'd3,
    CFG_O_LIMIT  = 3'd4,
    CFG_MAX_OUT  = 3'd5
  } cfg_idx_t;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    U_NOP,
    U_LOAD,
    U_ERR,
    U_INT,
    U_MSEL_P,
    U_MSEL_I,
    U_DIV,
    U_MUL_P,
    U_MUL_I,
    U_DIFF,
    U_SCALE,
    U_OUT,
    U_CLEAR,
    U_EMIT
  } uop_t;

  // Jump conditions: taken jumps go to target, otherwise pc + 1
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_CLR,
    C_LOOP,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic [PL_W-1:0] p_limit;
    logic [W_W-1:0]  p_weight;
    logic [IL_W-1:0] i_limit;
    logic [W_W-1:0]  i_weight;
    logic [OL_W-1:0] o_limit;
    logic [OL_W-1:0] max_out;
  } cfg_t;

  typedef struct packed {
    uop_t uop;
    logic load;
  } ctrl_t;

  typedef struct packed {
    logic op_clr;
    logic out_busy;
  } stat_t;

  // Microprogram
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      4'd0:    w = '{uop: U_LOAD,   cond: C_NO_IN,    target: 4'd0};
      4'd1:    w = '{uop: U_ERR,    cond: C_CLR,      target: 4'd14};
      4'd2:    w = '{uop: U_INT,    cond: C_NEXT,     target: 4'd0};
      4'd3:    w = '{uop: U_MSEL_P, cond: C_NEXT,     target: 4'd0};
      4'd4:    w = '{uop: U_DIV,    cond: C_LOOP,     target: 4'd4};
      4'd5:    w = '{uop: U_MUL_P,  cond: C_NEXT,     target: 4'd0};
      4'd6:    w = '{uop: U_MSEL_I, cond: C_NEXT,     target: 4'd0};
      4'd7:    w = '{uop: U_DIV,    cond: C_LOOP,     target: 4'd7};
      4'd8:    w = '{uop: U_MUL_I,  cond: C_NEXT,     target: 4'd0};
      4'd9:    w = '{uop: U_DIFF,   cond: C_NEXT,     target: 4'd0};
      4'd10:   w = '{uop: U_SCALE,  cond: C_NEXT,     target: 4'd0};
      4'd11:   w = '{uop: U_OUT,    cond: C_ALWAYS,   target: 4'd15};
      4'd14:   w = '{uop: U_CLEAR,  cond: C_ALWAYS,   target: 4'd15};
      4'd15:   w = '{uop: U_EMIT,   cond: C_OUT_BUSY, target: 4'd15};
      default: w = '{uop: U_NOP,    cond: C_ALWAYS,   target: 4'd0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fpr_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fpr_seq #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fpr_pkg::stat_t stat,
  output fpr_pkg::ctrl_t     ctrl
);
  import fpr_pkg::*;

  localparam int LCW = $clog2(FRAC_BITS);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [LCW-1:0]  loop_r, loop_nxt;
  ucw_t            cw;
  logic            take;

  assign cw        = ucode(pc_r);
  assign in_stall  = (cw.uop != U_LOAD);
  assign ctrl.uop  = cw.uop;
  assign ctrl.load = (cw.uop == U_LOAD) && in_valid;

  // Condition select and next step
  always_comb begin
    unique case (cw.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !in_valid;
      C_CLR:      take = stat.op_clr;
      C_LOOP:     take = (loop_r != '0);
      C_OUT_BUSY: take = stat.out_busy;
      default:    take = 1'b0;
    endcase
    pc_nxt = take ? cw.target : pc_r + 1'b1;
  end

  // Divider bit counter
  always_comb begin
    loop_nxt = loop_r;
    if (cw.uop == U_MSEL_P || cw.uop == U_MSEL_I) begin
      loop_nxt = LCW'(FRAC_BITS - 1);
    end else if (cw.uop == U_DIV && loop_r != '0) begin
      loop_nxt = loop_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      loop_r <= '0;
    end else begin
      pc_r   <= pc_nxt;
      loop_r <= loop_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fpr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fpr_dp #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fpr_pkg::ctrl_t                ctrl,
  input  wire fpr_pkg::cfg_t                 cfg,
  input  wire logic                          in_op,
  input  wire logic signed [DATA_WIDTH-1:0]  in_target,
  input  wire logic signed [DATA_WIDTH-1:0]  in_measured,
  output fpr_pkg::stat_t                     stat,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]       out_drive,
  output logic                               out_limited
);
  import fpr_pkg::*;

  localparam int EW   = DATA_WIDTH + 1;
  localparam int SUMW = ((ACC_WIDTH > EW) ? ACC_WIDTH : EW) + 1;
  localparam int XW   = ((SUMW > IL_W + 2) ? SUMW : IL_W + 2) + 1;
  localparam int RW   = IL_W + 2;
  localparam int MW   = FRAC_BITS + 1;
  localparam int PW   = MW + W_W;
  localparam int DFW  = FRAC_BITS + 19;
  localparam int SW   = DFW + OL_W + 1;
  localparam int SH   = FRAC_BITS + 8;
  localparam int VW   = SW - SH;
  localparam int OXW  = (DATA_WIDTH > DRV_W) ? DATA_WIDTH : DRV_W;

  logic                          op_r;
  logic signed [DATA_WIDTH-1:0]  tgt_r, meas_r;
  logic signed [EW-1:0]          err_r, err_c;
  logic signed [ACC_WIDTH-1:0]   int_r, int_nxt, int_sat;
  logic signed [DRV_W-1:0]       prev_r, prev_nxt;
  logic                          hi_r, lo_r;
  logic [RW-1:0]                 rem_r, div_r;
  logic [FRAC_BITS-1:0]          q_r;
  logic [PW-1:0]                 acc_r, prod_r;
  logic signed [DFW-1:0]         diff_r;
  logic signed [SW-1:0]          scl_r;
  logic signed [DRV_W-1:0]       res_drive_r, out_drive_r;
  logic                          res_lim_r, out_lim_r;
  logic                          out_valid_r, out_valid_nxt;

  // Anti-windup test on the previous drive
  logic signed [DRV_W:0] prev_x, mo_x;
  logic                  frozen;
  assign prev_x = DRV_W'(prev_r) + (DRV_W+1)'(0);
  assign mo_x   = $signed((DRV_W+1)'(cfg.max_out));
  assign frozen = (prev_x >= mo_x) || (prev_x <= -mo_x);

  // Error and saturating integral
  logic signed [SUMW-1:0] sum_c;
  logic                   ovf;
  assign err_c = EW'(tgt_r) - EW'(meas_r);
  assign sum_c = SUMW'(int_r) + SUMW'(err_r);
  assign ovf   = sum_c[SUMW-1:ACC_WIDTH-1] != {(SUMW-ACC_WIDTH+1){sum_c[SUMW-1]}};
  always_comb begin
    if (!ovf) begin
      int_sat = sum_c[ACC_WIDTH-1:0];
    end else if (sum_c[SUMW-1]) begin
      int_sat = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    end else begin
      int_sat = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
  end

  // Ramp setup: range tests and dividend x + L over divisor 2L
  logic signed [XW-1:0] x_c, ls_c, xpl_c;
  logic [IL_W-1:0]      l_c;
  logic                 sel_i;
  assign sel_i = (ctrl.uop == U_MSEL_I);
  assign x_c   = sel_i ? XW'(int_r) : XW'(err_r);
  assign l_c   = sel_i ? cfg.i_limit : IL_W'(cfg.p_limit);
  assign ls_c  = $signed(XW'(l_c));
  assign xpl_c = x_c + ls_c;

  // Restoring divider, one quotient bit per step
  logic [RW-1:0] sh_c;
  logic          ge_c;
  assign sh_c = {rem_r[RW-2:0], 1'b0};
  assign ge_c = (sh_c >= div_r);

  // Membership times rule weight
  logic [MW-1:0]  mem_c;
  logic [W_W-1:0] wsel_c;
  logic [PW-1:0]  mul_c;
  always_comb begin
    if (hi_r) begin
      mem_c = {1'b1, {FRAC_BITS{1'b0}}};
    end else if (lo_r) begin
      mem_c = '0;
    end else begin
      mem_c = {1'b0, q_r};
    end
  end
  assign wsel_c = (ctrl.uop == U_MUL_I) ? cfg.i_weight : cfg.p_weight;
  assign mul_c  = PW'(mem_c) * PW'(wsel_c);

  // 2M - W, aligned to the membership fraction
  logic [PW-1:0]    msum_c;
  logic [W_W:0]     wsum_c;
  logic signed [DFW-1:0] diff_c;
  assign msum_c = acc_r + prod_r;
  assign wsum_c = {1'b0, cfg.p_weight} + {1'b0, cfg.i_weight};
  assign diff_c = $signed(DFW'({msum_c, 1'b0})) - $signed(DFW'({wsum_c, {FRAC_BITS{1'b0}}}));

  // Truncate toward zero, then the two clamps
  logic [SW-1:0]         bias_c;
  logic signed [SW-1:0]  rnd_c;
  logic signed [VW-1:0]  val_c, v1_c, ol_v, mo_v, v2_c;
  logic                  lim_c;
  assign bias_c = {{(SW-SH){1'b0}}, {SH{scl_r[SW-1]}}};
  assign rnd_c  = scl_r + $signed(bias_c);
  assign val_c  = $signed(rnd_c[SW-1:SH]);
  assign ol_v   = $signed(VW'(cfg.o_limit));
  assign mo_v   = $signed(VW'(cfg.max_out));
  always_comb begin
    if (val_c > ol_v) begin
      v1_c = ol_v;
    end else if (val_c < -ol_v) begin
      v1_c = -ol_v;
    end else begin
      v1_c = val_c;
    end
    lim_c = 1'b1;
    if (v1_c > mo_v) begin
      v2_c = mo_v;
    end else if (v1_c < -mo_v) begin
      v2_c = -mo_v;
    end else begin
      v2_c  = v1_c;
      lim_c = 1'b0;
    end
  end

  // Regulator state and output register
  assign stat.op_clr   = op_r;
  assign stat.out_busy = out_valid_r && out_stall;

  always_comb begin
    int_nxt       = int_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (ctrl.uop)
      U_INT:   if (!frozen) int_nxt = int_sat;
      U_OUT:   prev_nxt = v2_c[DRV_W-1:0];
      U_CLEAR: begin
        int_nxt  = '0;
        prev_nxt = '0;
      end
      U_EMIT:  if (!stat.out_busy) out_valid_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      int_r       <= int_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r   <= in_op;
      tgt_r  <= in_target;
      meas_r <= in_measured;
    end
    unique case (ctrl.uop)
      U_ERR: err_r <= err_c;
      U_MSEL_P, U_MSEL_I: begin
        hi_r  <= (x_c >= ls_c);
        lo_r  <= (x_c <= -ls_c);
        rem_r <= xpl_c[RW-1:0];
        div_r <= RW'({l_c, 1'b0});
        q_r   <= '0;
      end
      U_DIV: begin
        rem_r <= ge_c ? sh_c - div_r : sh_c;
        q_r   <= {q_r[FRAC_BITS-2:0], ge_c};
      end
      U_MUL_P: acc_r  <= mul_c;
      U_MUL_I: prod_r <= mul_c;
      U_DIFF:  diff_r <= diff_c;
      U_SCALE: scl_r  <= SW'(diff_r) * SW'($signed({1'b0, cfg.o_limit}));
      U_OUT: begin
        res_drive_r <= v2_c[DRV_W-1:0];
        res_lim_r   <= lim_c;
      end
      U_CLEAR: begin
        res_drive_r <= '0;
        res_lim_r   <= 1'b0;
      end
      U_EMIT: begin
        if (!stat.out_busy) begin
          out_drive_r <= res_drive_r;
          out_lim_r   <= res_lim_r;
        end
      end
      default: ;
    endcase
  end

  logic signed [OXW-1:0] drv_x;
  assign drv_x       = OXW'(out_drive_r);
  assign out_drive   = drv_x[DATA_WIDTH-1:0];
  assign out_limited = out_lim_r;
  assign out_valid   = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/fuzzy_pi_speed_regulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A beat is taken only while the sequencer waits at its load step, so a new beat waits
// until the last one has been emitted; a clear skips the ramps, goes through the clear step to emit.
// The work is paced by the shared restoring divider, one quotient bit per cycle, run
// once for each of the two membership ramps under the microcode sequencer.
// Reset (rst_n low, synchronous): integral and previous drive cleared, registers to
// their defaults, output empty. No clearing pass; an input is taken the cycle after.

module fuzzy_pi_speed_regulator #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [fpr_pkg::CFG_IW-1:0]          cfg_index,
  input  wire logic [fpr_pkg::CFG_DW-1:0]          cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_op,
  input  wire logic signed [DATA_WIDTH-1:0]        in_target,
  input  wire logic signed [DATA_WIDTH-1:0]        in_measured,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [DATA_WIDTH-1:0]             out_drive,
  output logic                                     out_limited
);
  import fpr_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  ctrl_t ctrl;
  stat_t stat;

  // Register file; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_P_LIMIT:  cfg_nxt.p_limit  = cfg_data[PL_W-1:0];
        CFG_P_WEIGHT: cfg_nxt.p_weight = cfg_data[W_W-1:0];
        CFG_I_LIMIT:  cfg_nxt.i_limit  = cfg_data[IL_W-1:0];
        CFG_I_WEIGHT: cfg_nxt.i_weight = cfg_data[W_W-1:0];
        CFG_O_LIMIT:  cfg_nxt.o_limit  = cfg_data[OL_W-1:0];
        CFG_MAX_OUT:  cfg_nxt.max_out  = cfg_data[OL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_limit  <= P_LIMIT_RST;
      cfg_r.p_weight <= P_WEIGHT_RST;
      cfg_r.i_limit  <= I_LIMIT_RST;
      cfg_r.i_weight <= I_WEIGHT_RST;
      cfg_r.o_limit  <= O_LIMIT_RST;
      cfg_r.max_out  <= MAX_OUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fpr_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  fpr_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .cfg         (cfg_r),
    .in_op       (in_op),
    .in_target   (in_target),
    .in_measured (in_measured),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_drive   (out_drive),
    .out_limited (out_limited)
  );

endmodule

`default_nettype wire

// ===== tb/drive_checker.sv =====
`timescale 1ns / 1ps

// Watches the config port and both channels, keeps a shadow of the regulator
// state, and checks each output beat against the oldest predicted drive.
module drive_checker #(
  parameter int   DATA_WIDTH = 16,
  parameter int   ACC_WIDTH  = 32,
  parameter int   FRAC_BITS  = 16,
  parameter logic CLEAR_OP   = 1'b1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fpr_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [fpr_pkg::CFG_DW-1:0]      cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_op,
  input  logic signed [DATA_WIDTH-1:0]    in_target,
  input  logic signed [DATA_WIDTH-1:0]    in_measured,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [DATA_WIDTH-1:0]    out_drive,
  input  logic                            out_limited,
  output int                              fail_count,
  output int                              pending,
  output int                              result_beats
);
  import fpr_pkg::*;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         limited;
  } drive_beat_t;

  drive_beat_t drive_q[$];

  // Shadow registers
  logic [PL_W-1:0] p_limit_r;
  logic [W_W-1:0]  p_weight_r;
  logic [IL_W-1:0] i_limit_r;
  logic [W_W-1:0]  i_weight_r;
  logic [OL_W-1:0] o_limit_r;
  logic [OL_W-1:0] max_out_r;

  // Shadow regulator state
  longint integ_acc;
  longint last_drive;

  // Ramp membership over [-half, half]; 1.0 is 2^FRAC_BITS
  function automatic longint ramp_share(input longint x, input longint half);
    if (x >= half) return longint'(1) << FRAC_BITS;
    if (x <= -half) return 0;
    return ((x + half) << FRAC_BITS) / (2 * half);
  endfunction

  // One regulator step; updates the shadow state
  function automatic drive_beat_t regulate_step(input logic op,
                                                input logic signed [DATA_WIDTH-1:0] tgt,
                                                input logic signed [DATA_WIDTH-1:0] meas);
    drive_beat_t res;
    longint err, mo, ol, acc_max, msum, wsum, diff, val;
    res = '0;
    if (op == CLEAR_OP) begin
      integ_acc  = 0;
      last_drive = 0;
      return res;
    end
    err = longint'(tgt) - longint'(meas);
    mo  = longint'(max_out_r);
    ol  = longint'(o_limit_r);
    // anti-windup: hold the integral while the last drive sat at the clamp
    if (!(last_drive >= mo || last_drive <= -mo)) begin
      acc_max   = (longint'(1) << (ACC_WIDTH - 1)) - 1;
      integ_acc = integ_acc + err;
      if (integ_acc > acc_max) integ_acc = acc_max;
      if (integ_acc < -acc_max - 1) integ_acc = -acc_max - 1;
    end
    msum = ramp_share(err, longint'(p_limit_r)) * longint'(p_weight_r)
         + ramp_share(integ_acc, longint'(i_limit_r)) * longint'(i_weight_r);
    wsum = (longint'(p_weight_r) + longint'(i_weight_r)) << FRAC_BITS;
    diff = 2 * msum - wsum;
    val  = (ol * diff) / (longint'(1) << (FRAC_BITS + 8));
    if (val > ol) val = ol;
    if (val < -ol) val = -ol;
    if (val > mo) begin
      val = mo;
      res.limited = 1'b1;
    end else if (val < -mo) begin
      val = -mo;
      res.limited = 1'b1;
    end
    last_drive = val;
    res.drive  = val[DATA_WIDTH-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    drive_beat_t want;
    if (!rst_n) begin
      p_limit_r  = P_LIMIT_RST;
      p_weight_r = P_WEIGHT_RST;
      i_limit_r  = I_LIMIT_RST;
      i_weight_r = I_WEIGHT_RST;
      o_limit_r  = O_LIMIT_RST;
      max_out_r  = MAX_OUT_RST;
      integ_acc  = 0;
      last_drive = 0;
      drive_q.delete();
    end else begin
      // output beat belongs to an older input, so check it first
      if (out_valid && !out_stall) begin
        result_beats++;
        if (drive_q.size() == 0) begin
          fail_count++;
          $error("output beat with no prediction waiting: drive %0d limited %0b",
                 out_drive, out_limited);
        end else begin
          want = drive_q.pop_front();
          if (out_drive !== want.drive) begin
            fail_count++;
            $error("drive mismatch: expected %0d, got %0d", want.drive, out_drive);
          end
          if (out_limited !== want.limited) begin
            fail_count++;
            $error("limited mismatch: expected %0b, got %0b", want.limited, out_limited);
          end
        end
      end
      // register writes; bits above each width are dropped
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_P_LIMIT:  p_limit_r  = cfg_data[PL_W-1:0];
          CFG_P_WEIGHT: p_weight_r = cfg_data[W_W-1:0];
          CFG_I_LIMIT:  i_limit_r  = cfg_data[IL_W-1:0];
          CFG_I_WEIGHT: i_weight_r = cfg_data[W_W-1:0];
          CFG_O_LIMIT:  o_limit_r  = cfg_data[OL_W-1:0];
          CFG_MAX_OUT:  max_out_r  = cfg_data[OL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        drive_q.push_back(regulate_step(in_op, in_target, in_measured));
    end
    pending = drive_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import fpr_pkg::*;

  localparam int DATA_WIDTH = 16;
  localparam int ACC_WIDTH  = 32;
  localparam int FRAC_BITS  = 16;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // unused register slots
  localparam logic [CFG_IW-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IW-1:0] IDX_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_BLOCKS  = 3;
  localparam int BLOCK_BEATS   = 50;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [CFG_IW-1:0]            cfg_index;
  logic [CFG_DW-1:0]            cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_op;
  logic signed [DATA_WIDTH-1:0] in_target;
  logic signed [DATA_WIDTH-1:0] in_measured;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [DATA_WIDTH-1:0] out_drive;
  logic                         out_limited;

  int fail_count;
  int pending;
  int result_beats;
  int cycle_cnt;
  int send_idle_pct;
  int recv_stall_pct;
  int sent_beats;
  int clear_beats;
  int setting_cnt;
  int wind_left;
  int wind_err;

  fuzzy_pi_speed_regulator #(
    .DATA_WIDTH(DATA_WIDTH),
    .ACC_WIDTH (ACC_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_target  (in_target),
    .in_measured(in_measured),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_drive  (out_drive),
    .out_limited(out_limited)
  );

  drive_checker #(
    .DATA_WIDTH(DATA_WIDTH),
    .ACC_WIDTH (ACC_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .CLEAR_OP  (OP_CLEAR)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_target   (in_target),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_drive   (out_drive),
    .out_limited (out_limited),
    .fail_count  (fail_count),
    .pending     (pending),
    .result_beats(result_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // Run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_cnt, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // Present one beat and hold it until taken; entered and left just after a falling edge
  task automatic send_beat(input logic op, input logic signed [DATA_WIDTH-1:0] tgt,
                           input logic signed [DATA_WIDTH-1:0] meas);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_op       = op;
    in_target   = tgt;
    in_measured = meas;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_beats++;
    if (op == OP_CLEAR) clear_beats++;
  endtask

  // Stop sending and let every predicted beat come out
  task automatic drain_results;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Sometimes fill the bits above the register width with junk
  function automatic logic [CFG_DW-1:0] widen(input logic [CFG_DW-1:0] v, input int w);
    logic [CFG_DW-1:0] keep;
    keep = (w >= CFG_DW) ? '1 : ((CFG_DW'(1) << w) - 1);
    if ($urandom_range(1) == 0) return v & keep;
    return (v & keep) | (CFG_DW'($urandom) & ~keep);
  endfunction

  function automatic logic [CFG_DW-1:0] pick_reg(input int unsigned hi,
                                                 input int unsigned typical);
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_DW'(hi);
      2:       return CFG_DW'(1);
      3:       return CFG_DW'($urandom_range(typical));
      default: return CFG_DW'($urandom_range(hi));
    endcase
  endfunction

  task automatic new_settings;
    drain_results;
    write_reg(CFG_P_LIMIT,  widen(pick_reg(65535, 3000), PL_W));
    write_reg(CFG_P_WEIGHT, widen(pick_reg(65535, 512), W_W));
    write_reg(CFG_I_LIMIT,  widen(pick_reg(32'h7FFF_FFFF, 200000), IL_W));
    write_reg(CFG_I_WEIGHT, widen(pick_reg(65535, 512), W_W));
    write_reg(CFG_O_LIMIT,  widen(pick_reg(32767, 32767), OL_W));
    write_reg(CFG_MAX_OUT,  widen(pick_reg(32767, 32767), OL_W));
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? IDX_SPARE_HI : IDX_SPARE_LO, CFG_DW'($urandom));
    setting_cnt++;
  endtask

  // Mostly runs of same-sign error that wind the integral, plus near-zero and raw noise and occasional clears
  task automatic random_beat;
    int kind;
    int span;
    int err;
    int tgt;
    logic signed [DATA_WIDTH-1:0] meas;
    kind = $urandom_range(99);
    meas = DATA_WIDTH'($urandom);
    case ($urandom_range(3))
      0:       span = 4;
      1:       span = 300;
      2:       span = 3000;
      default: span = 40000;
    endcase
    if (kind < 4) begin
      send_beat(OP_CLEAR, DATA_WIDTH'($urandom), DATA_WIDTH'($urandom));
    end else if (kind < 85) begin
      if (kind < 60) begin
        if (wind_left == 0) begin
          wind_left = $urandom_range(3, 16);
          wind_err  = int'($urandom_range(2 * span)) - span;
        end
        wind_left--;
        err = wind_err + int'($urandom_range(6)) - 3;
      end else begin
        err = int'($urandom_range(2 * span)) - span;
      end
      tgt = meas + err;
      if (tgt > 32767) tgt = 32767;
      if (tgt < -32768) tgt = -32768;
      send_beat(OP_STEP, tgt[DATA_WIDTH-1:0], meas);
    end else begin
      send_beat(OP_STEP, DATA_WIDTH'($urandom), meas);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_P_LIMIT;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_op          = OP_STEP;
    in_target      = '0;
    in_measured    = '0;
    send_idle_pct  = 11;
    recv_stall_pct = 69;
    sent_beats     = 0;
    clear_beats    = 0;
    setting_cnt    = 1;
    wind_left      = 0;
    wind_err       = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset settings, field extremes, ramp edges
    send_beat(OP_STEP, 16'sd0, 16'sd0);
    send_beat(OP_STEP, 16'sd32767, -16'sd32768);
    send_beat(OP_STEP, -16'sd32768, 16'sd32767);
    send_beat(OP_CLEAR, 16'sd0, 16'sd0);
    send_beat(OP_STEP, 16'sd1000, 16'sd0);
    send_beat(OP_STEP, 16'sd0, 16'sd999);
    send_beat(OP_STEP, -16'sd1000, 16'sd0);
    send_beat(OP_CLEAR, -16'sd1, 16'sd1);

    // zero ramp half spans (written with junk above the width), and spare indexes
    drain_results;
    write_reg(CFG_P_LIMIT, 31'h7FFF_0000);
    write_reg(CFG_I_LIMIT, 31'd0);
    write_reg(IDX_SPARE_LO, 31'h7FFF_FFFF);
    write_reg(IDX_SPARE_HI, 31'd12345);
    setting_cnt++;
    send_beat(OP_STEP, 16'sd0, 16'sd0);
    send_beat(OP_STEP, -16'sd1, 16'sd0);
    send_beat(OP_CLEAR, 16'sd0, 16'sd0);

    // zero output scale
    drain_results;
    write_reg(CFG_O_LIMIT, 31'd0);
    setting_cnt++;
    send_beat(OP_STEP, 16'sd100, -16'sd100);
    send_beat(OP_STEP, -16'sd500, 16'sd0);

    // full output scale via a wide write, zero final clamp keeps the integral frozen
    drain_results;
    write_reg(CFG_O_LIMIT, 31'h7FFF_FFFF);
    write_reg(CFG_MAX_OUT, 31'd0);
    setting_cnt++;
    send_beat(OP_STEP, 16'sd300, 16'sd0);
    send_beat(OP_STEP, -16'sd300, 16'sd0);
    send_beat(OP_CLEAR, 16'sd0, 16'sd0);

    // small final clamp, heavy weights: limited drive and anti-windup
    drain_results;
    write_reg(CFG_P_LIMIT, 31'd1000);
    write_reg(CFG_I_LIMIT, 31'd100000);
    write_reg(CFG_P_WEIGHT, 31'd65535);
    write_reg(CFG_I_WEIGHT, 31'd65535);
    write_reg(CFG_MAX_OUT, 31'd200);
    setting_cnt++;
    send_beat(OP_STEP, 16'sd20000, 16'sd0);
    send_beat(OP_STEP, 16'sd20000, 16'sd0);
    send_beat(OP_STEP, -16'sd20000, 16'sd0);
    send_beat(OP_CLEAR, 16'sd0, 16'sd0);

    // Random: three idle mixes, several register settings each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 11;
          recv_stall_pct = 69;
        end
        1: begin
          send_idle_pct  = 69;
          recv_stall_pct = 11;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int blk = 0; blk < PHASE_BLOCKS; blk++) begin
        new_settings;
        for (int n = 0; n < BLOCK_BEATS; n++) begin
          // now and then hold off until the block has emptied
          if (n % 23 == 11) drain_results;
          random_beat;
        end
      end
    end

    drain_results;
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Sent %0d beats (%0d clears), checked %0d drive beats over %0d settings,",
             sent_beats, clear_beats, result_beats, setting_cnt);
    $display("with sender gaps and receiver stalls in both mixes and a run with neither.");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fpr_pkg.sv
rtl/core/fpr_seq.sv
rtl/core/fpr_dp.sv
rtl/core/fuzzy_pi_speed_regulator.sv
tb/drive_checker.sv
tb/testbench.sv
